// ===== hw/rtl/bdc_pkg.sv =====
// bdc_pkg: shared types, constants and calendar helper functions
// for the business day counter; no dependencies
`default_nettype none

package bdc_pkg;

  localparam int QueueDepthDef = 2;

  localparam int YearW  = 14;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int YyW    = 15;
  localparam int Q100W  = 9;
  localparam int DoyW   = 9;
  localparam int SerW   = 23;
  localparam int QuoW   = 21;
  localparam int CntW   = 24;
  localparam int CountW = 16;
  localparam int WdayW  = 3;

  localparam logic [12:0]       RecipHundred = 13'd5243;
  localparam logic [23:0]       RecipSeven   = 24'd9586981;
  localparam logic [YyW-1:0]    YearShift    = 15'd400;
  localparam logic [SerW-1:0]   WdayOffset   = 23'd3;
  localparam logic [WdayW-1:0]  FirstWeekend = 3'd5;
  localparam logic [WdayW-1:0]  WeekLen      = 3'd7;
  localparam logic [MonW-1:0]   MonFeb       = 4'd2;
  localparam logic [MonW-1:0]   MonDec       = 4'd12;
  localparam logic [DayW-1:0]   LeapFebLen   = 5'd29;

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // day of year counted from march 1
  localparam logic [DoyW-1:0] DoyBase [12] = '{
    9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153, 9'd184, 9'd214,
    9'd245, 9'd275
  };

  typedef struct packed {
    logic            ok;
    logic [YyW-1:0]  yy;
    logic [DoyW-1:0] doy;
  } bdc_date_t;

  typedef struct packed {
    bdc_date_t first;
    bdc_date_t last;
  } bdc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bdc_fifo_status_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkQuot,
    BkSer,
    BkMod,
    BkDiv,
    BkDone
  } bdc_back_state_e;

  function automatic logic [Q100W-1:0] div100(input logic [YyW-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RecipHundred);
    return p[27:19];
  endfunction

  function automatic logic [QuoW-1:0] div7(input logic [SerW-1:0] x);
    logic [46:0] p;
    p = 47'(x) * 47'(RecipSeven);
    return p[46:26];
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [Q100W-1:0] q;
    logic [YyW-1:0]   hund;
    logic             rem0;
    q    = div100(YyW'(y));
    hund = YyW'(q) * YyW'(100);
    rem0 = (YyW'(y) == hund);
    return ((y[1:0] == 2'd0) && !rem0) || (rem0 && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    if ((m == '0) || (m > MonDec)) begin
      len = '0;
    end else if ((m == MonFeb) && leap) begin
      len = LeapFebLen;
    end else begin
      len = MonthLen[4'(m - 4'd1)];
    end
    return len;
  endfunction

  function automatic logic [DoyW-1:0] doy_base(input logic [MonW-1:0] m);
    logic [DoyW-1:0] b;
    if ((m == '0) || (m > MonDec)) begin
      b = '0;
    end else begin
      b = DoyBase[4'(m - 4'd1)];
    end
    return b;
  endfunction

  // working days among the first r days of a week that starts on weekday sw
  function automatic logic [WdayW-1:0] partial_days(input logic [WdayW-1:0] sw,
                                                    input logic [WdayW-1:0] r);
    logic [WdayW-1:0] cnt;
    logic [WdayW:0]   w;
    cnt = '0;
    for (int i = 0; i < 6; i++) begin
      w = 4'(sw) + 4'(i);
      if (w >= 4'(WeekLen)) begin
        w = w - 4'(WeekLen);
      end
      if ((3'(i) < r) && (w < 4'(FirstWeekend))) begin
        cnt = cnt + 3'd1;
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdc_front.sv =====
// bdc_front: input register and date classification (validity, shifted year,
// day of year); depends on bdc_pkg
`default_nettype none

module bdc_front import bdc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [YearW-1:0] start_year_i,
  input  wire logic [MonW-1:0]  start_month_i,
  input  wire logic [DayW-1:0]  start_day_i,
  input  wire logic [YearW-1:0] end_year_i,
  input  wire logic [MonW-1:0]  end_month_i,
  input  wire logic [DayW-1:0]  end_day_i,
  input  wire logic             fifo_full_i,
  output logic                  push_o,
  output bdc_item_t             item_o
);

  logic             valid_q, valid_d;
  logic [YearW-1:0] sy_q, ey_q;
  logic [MonW-1:0]  sm_q, em_q;
  logic [DayW-1:0]  sd_q, ed_q;
  logic             load;

  function automatic bdc_date_t classify(input logic [YearW-1:0] y,
                                         input logic [MonW-1:0]  m,
                                         input logic [DayW-1:0]  d);
    logic            leap;
    logic [DayW-1:0] len;
    logic            early;
    bdc_date_t       r;
    leap  = is_leap(y);
    len   = month_len(m, leap);
    early = (m <= MonFeb);
    r.ok  = (len != '0) && (d != '0) && (d <= len);
    r.yy  = YyW'(y) + YearShift - YyW'(early);
    r.doy = doy_base(m) + DoyW'(d) - DoyW'(1);
    return r;
  endfunction

  assign push_o     = valid_q && !fifo_full_i;
  assign in_ready_o = !valid_q || !fifo_full_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sy_q <= start_year_i;
      sm_q <= start_month_i;
      sd_q <= start_day_i;
      ey_q <= end_year_i;
      em_q <= end_month_i;
      ed_q <= end_day_i;
    end
  end

  assign item_o.first = classify(sy_q, sm_q, sd_q);
  assign item_o.last  = classify(ey_q, em_q, ed_q);

endmodule

`default_nettype wire

// ===== hw/rtl/bdc_fifo.sv =====
// bdc_fifo: short queue of classified items between front and back;
// depends on bdc_pkg
`default_nettype none

module bdc_fifo import bdc_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire bdc_item_t  item_i,
  input  wire logic       pop_i,
  output bdc_item_t       item_o,
  output bdc_fifo_status_t status_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  bdc_item_t        mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdc_back.sv =====
// bdc_back: sequencer that turns a classified item into day serials, weekdays
// and the working day count, with the output register; depends on bdc_pkg
`default_nettype none

module bdc_back import bdc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bdc_item_t         item_i,
  input  wire logic              fifo_empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CountW-1:0]      business_days_o,
  output logic                   count_saturated_o,
  output logic                   date_invalid_o,
  output logic [WdayW-1:0]       start_weekday_o,
  output logic [WdayW-1:0]       end_weekday_o
);

  bdc_back_state_e  state_q, state_d;
  bdc_item_t        item_q;
  logic [Q100W-1:0] q100s_q, q100e_q;
  logic [SerW-1:0]  sers_q, sere_q;
  logic [SerW-1:0]  xs_q, xe_q, n_q;
  logic [QuoW-1:0]  qs_q, qe_q, qn_q;
  logic             out_valid_q, out_valid_d;
  logic             load_out;

  logic [SerW-1:0]  ts, te, tn;
  logic [WdayW-1:0] rs, re, rn;
  logic [CntW-1:0]  cnt;
  logic             both_ok, sat;

  function automatic logic [SerW-1:0] serial(input bdc_date_t dt, input logic [Q100W-1:0] q);
    return SerW'(dt.yy) * SerW'(365) + SerW'(dt.yy[YyW-1:2]) - SerW'(q)
           + SerW'(q[Q100W-1:2]) + SerW'(dt.doy);
  endfunction

  assign pop_o    = (state_q == BkIdle) && !fifo_empty_i;
  assign load_out = (state_q == BkDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (!fifo_empty_i) state_d = BkQuot;
      BkQuot: state_d = BkSer;
      BkSer:  state_d = BkMod;
      BkMod:  state_d = BkDiv;
      BkDiv:  state_d = BkDone;
      BkDone: if (load_out) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q == BkQuot) begin
      q100s_q <= div100(item_q.first.yy);
      q100e_q <= div100(item_q.last.yy);
    end
    if (state_q == BkSer) begin
      sers_q <= serial(item_q.first, q100s_q);
      sere_q <= serial(item_q.last, q100e_q);
    end
    if (state_q == BkMod) begin
      xs_q <= sers_q + WdayOffset;
      xe_q <= sere_q + WdayOffset;
      n_q  <= (sers_q < sere_q) ? sere_q - sers_q : '0;
    end
    if (state_q == BkDiv) begin
      qs_q <= div7(xs_q);
      qe_q <= div7(xe_q);
      qn_q <= div7(n_q);
    end
  end

  // remainders and count for the finishing step
  always_comb begin
    ts      = xs_q - SerW'(qs_q) * SerW'(WeekLen);
    te      = xe_q - SerW'(qe_q) * SerW'(WeekLen);
    tn      = n_q - SerW'(qn_q) * SerW'(WeekLen);
    rs      = ts[WdayW-1:0];
    re      = te[WdayW-1:0];
    rn      = tn[WdayW-1:0];
    cnt     = CntW'(qn_q) * CntW'(5) + CntW'(partial_days(rs, rn));
    both_ok = item_q.first.ok && item_q.last.ok;
    sat     = both_ok && (cnt[CntW-1:CountW] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      business_days_o   <= !both_ok ? '0 : (sat ? '1 : cnt[CountW-1:0]);
      count_saturated_o <= sat;
      date_invalid_o    <= !both_ok;
      start_weekday_o   <= item_q.first.ok ? rs : '0;
      end_weekday_o     <= item_q.last.ok ? re : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/business_day_counter_core.sv =====
// business_day_counter_core: top level joining front, queue and back;
// depends on bdc_pkg, bdc_front, bdc_fifo and bdc_back
//
// Counts the days other than Friday and Saturday from a start date, included,
// up to an end date, excluded, and returns the weekday (0 Sunday) of each date.
// A bad month or day sets date_invalid and gives a count of 0 and weekday 0
// for the bad date; a start not before the end gives 0; counts above 65535
// saturate with count_saturated set. The count is formed in closed form from
// day serial numbers, so the time per item does not depend on the span: the
// back sequencer steps each item through queue pop, year quotient by 100,
// serials, offsets, quotients by 7, and finish and output load, which waits
// while the output is stalled; it pops a new item only when idle, and the
// input register plus the queue let the next items enter meanwhile.
`default_nettype none

module business_day_counter_core import bdc_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [YearW-1:0] start_year_i,
  input  wire logic [MonW-1:0]  start_month_i,
  input  wire logic [DayW-1:0]  start_day_i,
  input  wire logic [YearW-1:0] end_year_i,
  input  wire logic [MonW-1:0]  end_month_i,
  input  wire logic [DayW-1:0]  end_day_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CountW-1:0]     business_days_o,
  output logic                  count_saturated_o,
  output logic                  date_invalid_o,
  output logic [WdayW-1:0]      start_weekday_o,
  output logic [WdayW-1:0]      end_weekday_o
);

  logic             push, pop;
  bdc_item_t        front_item, queue_item;
  bdc_fifo_status_t fifo_status;

  bdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_year_i  (start_year_i),
    .start_month_i (start_month_i),
    .start_day_i   (start_day_i),
    .end_year_i    (end_year_i),
    .end_month_i   (end_month_i),
    .end_day_i     (end_day_i),
    .fifo_full_i   (fifo_status.full),
    .push_o        (push),
    .item_o        (front_item)
  );

  bdc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (fifo_status)
  );

  bdc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (queue_item),
    .fifo_empty_i      (fifo_status.empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .business_days_o   (business_days_o),
    .count_saturated_o (count_saturated_o),
    .date_invalid_o    (date_invalid_o),
    .start_weekday_o   (start_weekday_o),
    .end_weekday_o     (end_weekday_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_business_day_counter_core.sv =====
// tb_business_day_counter_core: self-checking testbench for business_day_counter_core
// predicts the count, flags and weekdays of each date span and checks every result item
// depends on bdc_pkg and business_day_counter_core
`default_nettype none

module tb_business_day_counter_core;
  import bdc_pkg::*;

  localparam int unsigned DaysPerWeek = 7;
  localparam int unsigned WorkDaysPerWeek = 5;
  localparam int unsigned Friday = 5;
  localparam int unsigned CountMax = 65535;
  localparam int unsigned YearMax = 16383;
  localparam int RandomItems = 1616;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic [YearW-1:0] start_year;
    logic [MonW-1:0]  start_month;
    logic [DayW-1:0]  start_day;
    logic [YearW-1:0] end_year;
    logic [MonW-1:0]  end_month;
    logic [DayW-1:0]  end_day;
    logic             hold;
  } span_t;

  typedef struct packed {
    logic [CountW-1:0] days;
    logic              sat;
    logic              bad;
    logic [WdayW-1:0]  start_wd;
    logic [WdayW-1:0]  end_wd;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;
  span_t cur_span = '0;
  int gap_left = 0;
  int stall_left = 0;
  int sent = 0;
  int mismatches = 0;

  span_t pending_spans[$];
  tally_t expected_tallies[$];

  logic              in_ready;
  logic              out_valid;
  logic [CountW-1:0] business_days;
  logic              count_saturated;
  logic              date_invalid;
  logic [WdayW-1:0]  start_weekday;
  logic [WdayW-1:0]  end_weekday;

  business_day_counter_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .start_year_i      (cur_span.start_year),
    .start_month_i     (cur_span.start_month),
    .start_day_i       (cur_span.start_day),
    .end_year_i        (cur_span.end_year),
    .end_month_i       (cur_span.end_month),
    .end_day_i         (cur_span.end_day),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .business_days_o   (business_days),
    .count_saturated_o (count_saturated),
    .date_invalid_o    (date_invalid),
    .start_weekday_o   (start_weekday),
    .end_weekday_o     (end_weekday)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) begin
      return 0;
    end
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  function automatic bit date_good(int unsigned y, int unsigned m, int unsigned d);
    int unsigned len;
    len = month_days(m, y);
    return len != 0 && d >= 1 && d <= len;
  endfunction

  function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
    int unsigned a, yy, mm;
    a = (14 - m) / 12;
    yy = y + 400 - a;
    mm = m + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % DaysPerWeek;
  endfunction

  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned a, yy, mm, doy;
    a = (m <= 2) ? 1 : 0;
    yy = y + 400 - a;
    mm = m + 12 * a - 3;
    doy = (153 * mm + 2) / 5 + d - 1;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + doy;
  endfunction

  function automatic tally_t tally_span(span_t s);
    tally_t t;
    int unsigned sy, sm, sd, ey, em, ed;
    int unsigned sw, first, last, n, cnt;
    bit s_ok, e_ok;
    sy = s.start_year;
    sm = s.start_month;
    sd = s.start_day;
    ey = s.end_year;
    em = s.end_month;
    ed = s.end_day;
    s_ok = date_good(sy, sm, sd);
    e_ok = date_good(ey, em, ed);
    sw = s_ok ? day_of_week(sy, sm, sd) : 0;
    t = '0;
    t.start_wd = WdayW'(sw);
    t.end_wd = e_ok ? WdayW'(day_of_week(ey, em, ed)) : '0;
    t.bad = !(s_ok && e_ok);
    if (s_ok && e_ok) begin
      first = day_number(sy, sm, sd);
      last = day_number(ey, em, ed);
      if (first < last) begin
        n = last - first;
        cnt = (n / DaysPerWeek) * WorkDaysPerWeek;
        for (int i = 0; i < int'(n % DaysPerWeek); i++) begin
          if (((sw + i) % DaysPerWeek) < Friday) begin
            cnt++;
          end
        end
        if (cnt > CountMax) begin
          cnt = CountMax;
          t.sat = 1'b1;
        end
        t.days = CountW'(cnt);
      end
    end
    return t;
  endfunction

  function automatic span_t pack_span(int unsigned sy, int unsigned sm, int unsigned sd,
                                      int unsigned ey, int unsigned em, int unsigned ed);
    span_t s;
    s.start_year = YearW'(sy);
    s.start_month = MonW'(sm);
    s.start_day = DayW'(sd);
    s.end_year = YearW'(ey);
    s.end_month = MonW'(em);
    s.end_day = DayW'(ed);
    s.hold = 1'b0;
    return s;
  endfunction

  task automatic rand_date(input int unsigned ylo, input int unsigned yhi,
                           output int unsigned y, output int unsigned m, output int unsigned d);
    y = $urandom_range(yhi, ylo);
    m = $urandom_range(12, 1);
    d = $urandom_range(month_days(m, y), 1);
  endtask

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  task automatic check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_spans.size() != 0 &&
                   !(pending_spans[0].hold && expected_tallies.size() != 0)) begin
        cur_span <= pending_spans.pop_front();
        in_valid <= 1'b1;
        gap_left <= pick_gap(calm);
        sent <= sent + 1;
        calm <= ((sent / 150) % 4) == 2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap(calm);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tally_t exp_t;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_tallies.push_back(tally_span(cur_span));
      end
      if (out_valid && out_ready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual days %0d", $time,
                   business_days);
          mismatches++;
        end else begin
          exp_t = expected_tallies.pop_front();
          check_field("business_days", exp_t.days, business_days);
          check_field("count_saturated", exp_t.sat, count_saturated);
          check_field("date_invalid", exp_t.bad, date_invalid);
          check_field("start_weekday", exp_t.start_wd, start_weekday);
          check_field("end_weekday", exp_t.end_wd, end_weekday);
        end
      end
    end
  end

  initial begin
    int unsigned sy, sm, sd, ey, em, ed, sel;
    span_t s;
    pending_spans.push_back(pack_span(1, 1, 1, 1, 1, 2));
    pending_spans.push_back(pack_span(1, 1, 1, 9999, 12, 31));
    pending_spans.push_back(pack_span(0, 1, 1, YearMax, 12, 31));
    pending_spans.push_back(pack_span(9999, 12, 31, 1, 1, 1));
    pending_spans.push_back(pack_span(2024, 3, 15, 2024, 3, 15));
    pending_spans.push_back(pack_span(2000, 2, 29, 2000, 3, 1));
    pending_spans.push_back(pack_span(1900, 2, 29, 1900, 3, 1));
    pending_spans.push_back(pack_span(2024, 2, 29, 2023, 2, 29));
    pending_spans.push_back(pack_span(2024, 0, 10, 2024, 5, 1));
    pending_spans.push_back(pack_span(2024, 13, 1, 2025, 1, 1));
    pending_spans.push_back(pack_span(2024, 1, 1, 2024, 15, 31));
    pending_spans.push_back(pack_span(2024, 4, 0, 2024, 4, 30));
    pending_spans.push_back(pack_span(2024, 4, 31, 2024, 5, 1));
    pending_spans.push_back(pack_span(2024, 1, 31, 2024, 2, 1));
    pending_spans.push_back(pack_span(YearMax, 15, 31, 0, 0, 0));
    pending_spans.push_back(pack_span(2024, 1, 5, 2024, 1, 7));
    // partial weeks from a thursday, across the weekend
    for (int k = 1; k <= 7; k++) begin
      pending_spans.push_back(pack_span(2024, 1, 4, 2024, 1, 4 + k));
    end
    for (int k = 0; k < RandomItems; k++) begin
      sel = $urandom_range(99, 0);
      rand_date(1, 9999, sy, sm, sd);
      if (sel < 45) begin
        rand_date(sy, sy + 2, ey, em, ed);
      end else if (sel < 60) begin
        ey = sy;
        em = sm;
        ed = $urandom_range(month_days(sm, sy), 1);
      end else if (sel < 72) begin
        rand_date(0, YearMax, sy, sm, sd);
        rand_date(0, YearMax, ey, em, ed);
      end else if (sel < 82) begin
        rand_date((sy > 2) ? sy - 2 : 0, sy, ey, em, ed);
      end else if (sel < 90) begin
        rand_date(1, 9999, ey, em, ed);
        if (sel[0]) begin
          sd = month_days(sm, sy) + 1;
        end else begin
          ed = month_days(em, ey) + 1;
        end
      end else begin
        sy = $urandom_range(YearMax, 0);
        sm = $urandom_range(15, 0);
        sd = $urandom_range(31, 0);
        ey = $urandom_range(YearMax, 0);
        em = $urandom_range(15, 0);
        ed = $urandom_range(31, 0);
      end
      s = pack_span(sy, sm, sd, ey, em, ed);
      s.hold = (k == 0) || ($urandom_range(199, 0) == 0);
      pending_spans.push_back(s);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_spans.size() != 0 || in_valid || expected_tallies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** business_day_counter_core: PASSED **");
    end else begin
      $display("** business_day_counter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** business_day_counter_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_front.sv
hw/rtl/bdc_fifo.sv
hw/rtl/bdc_back.sv
hw/rtl/business_day_counter_core.sv
tb/tb_business_day_counter_core.sv
